FILE: hw/rtl/mexp_pkg.sv
package mexp_pkg;

  // Field widths of the item and result
  localparam int BASE_W  = 30;
  localparam int EXP_W   = 63;
  localparam int POWER_W = 30;

  // Number of exponent bits examined (1..63)
  localparam int EXP_BITS = 63;

  // Mask that keeps only the examined exponent bits
  localparam logic [EXP_W-1:0] EXP_MASK = EXP_W'((65'd1 << EXP_BITS) - 65'd1);

  // Modulus and derived reduction constants
  localparam logic [29:0] PRIME    = 30'd998244353;
  localparam logic [31:0] PRIME_X2 = 32'(2 * 64'(PRIME));
  localparam logic [31:0] PRIME_X3 = 32'(3 * 64'(PRIME));
  // Barrett reciprocal: floor(2^60 / PRIME), fits in 31 bits
  localparam logic [30:0] MU_C     = 31'((64'd1 << 60) / 64'(PRIME));

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } mexp_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic issue_sq;
    logic issue_mul;
    logic shift;
    logic finish;
  } mexp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mul_busy;
    logic exp_zero;
    logic exp_bit0;
    logic out_free;
  } mexp_sts_t;

endpackage

FILE: hw/rtl/mexp_mulmod.sv
module mexp_mulmod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        op_valid,
  input  logic        op_tag,
  input  logic [29:0] op_a,
  input  logic [29:0] op_b,
  output logic        res_valid,
  output logic        res_tag,
  output logic [29:0] res,
  output logic        busy
);
  import mexp_pkg::*;

  logic [4:0]  v_r, v_nxt;
  logic [4:0]  tag_r, tag_nxt;
  logic [59:0] x1_r, x1_nxt;
  logic [61:0] t2_r, t2_nxt;
  logic [31:0] x2_r, x3_r;
  logic [31:0] qp3_r, qp3_nxt;
  logic [60:0] qp_full;
  logic [31:0] r4_r, r4_nxt;
  logic [29:0] res5_r, res5_nxt;

  // Stage 1: full product
  assign x1_nxt = {30'd0, op_a} * {30'd0, op_b};

  // Stage 2: quotient estimate from the top bits times the reciprocal
  assign t2_nxt = {31'd0, x1_r[59:29]} * {31'd0, MU_C};

  // Stage 3: quotient times modulus, low word is all that matters
  assign qp_full = {30'd0, t2_r[61:31]} * {31'd0, PRIME};
  assign qp3_nxt = qp_full[31:0];

  // Stage 4: remainder candidate, below three times the modulus
  assign r4_nxt = x3_r - qp3_r;

  // Stage 5: final correction by zero, one or two moduli
  always_comb begin
    if (r4_r >= PRIME_X2) begin
      res5_nxt = 30'(r4_r - PRIME_X2);
    end else if (r4_r >= {2'b00, PRIME}) begin
      res5_nxt = 30'(r4_r - {2'b00, PRIME});
    end else begin
      res5_nxt = r4_r[29:0];
    end
  end

  // Advance valid and tag through the stages
  assign v_nxt   = {v_r[3:0], op_valid};
  assign tag_nxt = {tag_r[3:0], op_tag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload stages, no reset needed
  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    x1_r   <= x1_nxt;
    t2_r   <= t2_nxt;
    x2_r   <= x1_r[31:0];
    qp3_r  <= qp3_nxt;
    x3_r   <= x2_r;
    r4_r   <= r4_nxt;
    res5_r <= res5_nxt;
  end

  assign res_valid = v_r[4];
  assign res_tag   = tag_r[4];
  assign res       = res5_r;
  assign busy      = |v_r;

  // Remainder candidate must stay below three moduli
  a_r4_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (r4_r < PRIME_X3))
    else $error("remainder candidate out of range");

  // Result is fully reduced
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (res5_r < PRIME))
    else $error("multiplier result not reduced");

endmodule

FILE: hw/rtl/mexp_datapath.sv
module mexp_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mexp_pkg::mexp_cmd_t          cmd,
  output mexp_pkg::mexp_sts_t          sts,
  input  logic [mexp_pkg::BASE_W-1:0]  in_base,
  input  logic [mexp_pkg::EXP_W-1:0]   in_exponent,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mexp_pkg::POWER_W-1:0] out_power
);
  import mexp_pkg::*;

  logic [29:0]      b_r, b_nxt;
  logic [29:0]      acc_r, acc_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [29:0]      out_power_r, out_power_nxt;
  logic [29:0]      base_red;
  logic             mul_valid;
  logic [29:0]      mul_a;
  logic             res_valid;
  logic             res_tag;
  logic [29:0]      res;
  logic             mul_busy;

  // Reduce the base once: it is below twice the modulus
  assign base_red = (in_base >= PRIME) ? (in_base - PRIME) : in_base;

  // Feed the shared multiplier: square uses b twice, multiply uses acc and b
  assign mul_valid = cmd.issue_sq | cmd.issue_mul;
  assign mul_a     = cmd.issue_sq ? b_r : acc_r;

  mexp_mulmod u_mulmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (mul_valid),
    .op_tag    (cmd.issue_sq),
    .op_a      (mul_a),
    .op_b      (b_r),
    .res_valid (res_valid),
    .res_tag   (res_tag),
    .res       (res),
    .busy      (mul_busy)
  );

  // Load operands, write back products, shift the exponent
  always_comb begin
    b_nxt   = b_r;
    acc_nxt = acc_r;
    exp_nxt = exp_r;
    if (cmd.load) begin
      b_nxt   = base_red;
      acc_nxt = 30'd1;
      exp_nxt = in_exponent & EXP_MASK;
    end else begin
      if (res_valid && res_tag) begin
        b_nxt = res;
      end
      if (res_valid && !res_tag) begin
        acc_nxt = res;
      end
      if (cmd.shift) begin
        exp_nxt = exp_r >> 1;
      end
    end
  end

  // Output register: hold until taken, refill when free
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_power_nxt = out_power_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_power_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r         <= b_nxt;
    acc_r       <= acc_nxt;
    exp_r       <= exp_nxt;
    out_power_r <= out_power_nxt;
  end

  assign sts.mul_busy = mul_busy;
  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_bit0 = exp_r[0];
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  // No product may still be in flight when the result is taken
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !mul_busy)
    else $error("result taken with multiplier busy");

  // A new item never overwrites operands that the multiplier still owes
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !mul_busy)
    else $error("item loaded with multiplier busy");

endmodule

FILE: hw/rtl/mexp_ctrl.sv
module mexp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mexp_pkg::mexp_sts_t sts,
  output mexp_pkg::mexp_cmd_t cmd
);
  import mexp_pkg::*;

  mexp_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!sts.mul_busy) begin
          state_nxt = sts.exp_zero ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_SQUARE: state_nxt = ST_MULT;
      ST_MULT:   state_nxt = ST_WAIT;
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SQUARE: begin
        cmd.issue_sq = 1'b1;
      end
      ST_MULT: begin
        cmd.issue_mul = sts.exp_bit0;
        cmd.shift     = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Leaving the wait state for a new bit needs the multiplier drained
  a_wait_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && state_nxt == ST_SQUARE) |-> (!sts.mul_busy && !sts.exp_zero))
    else $error("bit started before previous products returned");

endmodule

FILE: hw/rtl/modular_exponentiation_core.sv
// Each exponent bit up to the highest set bit is processed in turn, lowest first; a zero exponent
// goes straight to the result without any multiplier step.
// A new item is accepted only once the previous result has entered the output register; a set bit takes a
// square and a multiply through the shared five-stage multiplier plus its drain,
// a clear bit only the square and its drain.
// Reset: synchronous active-low rst_n clears the controller and output valid.
module modular_exponentiation_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mexp_pkg::BASE_W-1:0]  in_base,
  input  logic [mexp_pkg::EXP_W-1:0]   in_exponent,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mexp_pkg::POWER_W-1:0] out_power
);
  import mexp_pkg::*;

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  // Sequence the square-and-multiply steps
  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold operands, multiplier and result register
  mexp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_power   (out_power)
  );

endmodule
